>>> design/button_long_press_and_multi_tap_defines.svh
// Assertion helpers used by the checker file.
`ifndef BUTTON_LONG_PRESS_AND_MULTI_TAP_DEFINES_SVH
`define BUTTON_LONG_PRESS_AND_MULTI_TAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BLPMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blpmt assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BLPMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blpmt assertion failed");

`endif

>>> design/blpmt_pkg.sv
`default_nettype none
package blpmt_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CMP_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    localparam int IN_BYTES  = 1;
    localparam int OUT_BYTES = 1;
    localparam int ADDR_W    = 5;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // register indexes
    localparam logic [2:0] REG_HOLD_TICKS        = 3'd0;
    localparam logic [2:0] REG_LOCKOUT_TICKS     = 3'd1;
    localparam logic [2:0] REG_TAP_TICKS         = 3'd2;
    localparam logic [2:0] REG_TAP_RELEASE_TICKS = 3'd3;
    localparam logic [2:0] REG_TAPS_FOR_RESET    = 3'd4;
    localparam logic [2:0] REG_TAP_WINDOW_TICKS  = 3'd5;

    // reset values
    localparam logic [15:0] RST_HOLD_TICKS        = 16'd750;
    localparam logic [15:0] RST_LOCKOUT_TICKS     = 16'd5000;
    localparam logic [15:0] RST_TAP_TICKS         = 16'd100;
    localparam logic [15:0] RST_TAP_RELEASE_TICKS = 16'd750;
    localparam logic [7:0]  RST_TAPS_FOR_RESET    = 8'd3;
    localparam logic [15:0] RST_TAP_WINDOW_TICKS  = 16'd5000;

    // status codes
    localparam logic [1:0] ST_READY  = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    // output tdata bit positions
    localparam int OB_START   = 0;
    localparam int OB_ACTION  = 1;
    localparam int OB_DISPLAY = 2;
    localparam int OB_RESET   = 3;
    localparam int OB_LOCKED  = 4;

endpackage
`default_nettype wire

>>> design/button_long_press_and_multi_tap.sv
// Each tick's result is registered in the output register; the input is ready
// whenever the output register is empty or being taken. Throughput: one tick
// per cycle unless the output stalls, set by the single-pass update.
// Reset (i_rst_n low, synchronous): counters and flags cleared, thresholds
// back to their defaults, output register empty. A tap reset request clears
// counters, flags and thresholds the same way but still delivers its result.
`default_nettype none
module button_long_press_and_multi_tap
    import blpmt_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [0] button_pressed, [2:1] status_code, [7:3] zero
    input  wire logic [8*IN_BYTES-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [0] start_request, [1] action_level, [2] display_request,
    // [3] reset_request, [4] long_press_locked, [7:5] zero
    output logic [8*OUT_BYTES-1:0]      o_m_axis_tdata,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [15:0] r_hold_ticks, r_lockout_ticks, r_tap_ticks;
    logic [15:0] r_tap_release_ticks, r_tap_window_ticks;
    logic [7:0]  r_taps_for_reset;

    t_count r_hold, r_lockout, r_tap_press, r_tap_release, r_tap_window;
    t_count n_hold, n_lockout, n_tap_press, n_tap_release, n_tap_window;
    logic   r_long_locked, r_tap_latched, r_action;
    logic   n_long_locked, n_tap_latched, n_action;
    logic [7:0] r_tap_total, n_tap_total;

    logic       r_out_valid;
    logic [8*OUT_BYTES-1:0] r_out_data, n_out_data;

    logic s_fire, step_rst, start, display, pressed, wr_en;
    logic [1:0] status;

    function automatic logic cnt_ge(input t_count c, input logic [15:0] t);
        cnt_ge = CMP_W'(c) >= CMP_W'(t);
    endfunction

    assign pready          = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign wr_en           = psel && penable && pwrite && pready;
    assign pressed         = i_s_axis_tdata[0];
    assign status          = i_s_axis_tdata[2:1];

    always_comb begin
        n_hold        = r_hold;
        n_lockout     = r_lockout;
        n_tap_press   = r_tap_press;
        n_tap_release = r_tap_release;
        n_tap_window  = r_tap_window;
        n_long_locked = r_long_locked;
        n_tap_latched = r_tap_latched;
        n_action      = r_action;
        n_tap_total   = r_tap_total;
        start         = 1'b0;
        display       = 1'b0;
        step_rst      = 1'b0;

        // long press
        if (pressed && !n_long_locked) begin
            if (cnt_ge(n_hold, r_hold_ticks)) begin
                n_long_locked = 1'b1;
                n_tap_total   = '0;
                display       = 1'b1;
                case (status) inside
                    ST_READY:          start    = 1'b1;
                    ST_OPEN, ST_CLOSED: n_action = 1'b1;
                    default:           n_action = 1'b0;
                endcase
            end else begin
                n_hold = n_hold + COUNT_WIDTH'(1);
            end
        end else begin
            n_hold = '0;
        end

        if (n_long_locked) begin
            n_tap_total = '0;
            n_lockout   = n_lockout + COUNT_WIDTH'(1);
            if (cnt_ge(n_lockout, r_lockout_ticks)) begin
                n_long_locked = 1'b0;
                n_lockout     = '0;
                n_action      = 1'b0;
            end
        end

        // taps
        if (pressed && !n_tap_latched) begin
            if (cnt_ge(n_tap_press, r_tap_ticks)) begin
                n_tap_latched = 1'b1;
                n_tap_total   = n_tap_total + 8'd1;
            end else begin
                n_tap_press = n_tap_press + COUNT_WIDTH'(1);
            end
        end else begin
            n_tap_press = '0;
        end

        if (n_tap_latched) begin
            n_tap_release = n_tap_release + COUNT_WIDTH'(1);
            if (cnt_ge(n_tap_release, r_tap_release_ticks)) begin
                n_tap_latched = 1'b0;
                n_tap_release = '0;
            end
        end

        if (n_tap_total >= r_taps_for_reset) begin
            step_rst      = 1'b1;
            n_hold        = '0;
            n_lockout     = '0;
            n_tap_press   = '0;
            n_tap_release = '0;
            n_tap_window  = '0;
            n_long_locked = 1'b0;
            n_tap_latched = 1'b0;
            n_action      = 1'b0;
            n_tap_total   = '0;
        end else if (n_tap_total != 8'd0) begin
            n_tap_window = n_tap_window + COUNT_WIDTH'(1);
            if (cnt_ge(n_tap_window, r_tap_window_ticks)) begin
                n_tap_latched = 1'b0;
                n_tap_press   = '0;
                n_tap_release = '0;
                n_tap_total   = '0;
                n_tap_window  = '0;
            end
        end

        n_out_data             = '0;
        n_out_data[OB_START]   = start;
        n_out_data[OB_ACTION]  = n_action;
        n_out_data[OB_DISPLAY] = display;
        n_out_data[OB_RESET]   = step_rst;
        n_out_data[OB_LOCKED]  = n_long_locked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold        <= '0;
            r_lockout     <= '0;
            r_tap_press   <= '0;
            r_tap_release <= '0;
            r_tap_window  <= '0;
            r_long_locked <= 1'b0;
            r_tap_latched <= 1'b0;
            r_action      <= 1'b0;
            r_tap_total   <= '0;
        end else if (s_fire) begin
            r_hold        <= n_hold;
            r_lockout     <= n_lockout;
            r_tap_press   <= n_tap_press;
            r_tap_release <= n_tap_release;
            r_tap_window  <= n_tap_window;
            r_long_locked <= n_long_locked;
            r_tap_latched <= n_tap_latched;
            r_action      <= n_action;
            r_tap_total   <= n_tap_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s_fire && step_rst)) begin
            r_hold_ticks        <= RST_HOLD_TICKS;
            r_lockout_ticks     <= RST_LOCKOUT_TICKS;
            r_tap_ticks         <= RST_TAP_TICKS;
            r_tap_release_ticks <= RST_TAP_RELEASE_TICKS;
            r_taps_for_reset    <= RST_TAPS_FOR_RESET;
            r_tap_window_ticks  <= RST_TAP_WINDOW_TICKS;
        end else if (wr_en) begin
            unique case (paddr[ADDR_W-1:2])
                REG_HOLD_TICKS:        r_hold_ticks        <= pwdata[15:0];
                REG_LOCKOUT_TICKS:     r_lockout_ticks     <= pwdata[15:0];
                REG_TAP_TICKS:         r_tap_ticks         <= pwdata[15:0];
                REG_TAP_RELEASE_TICKS: r_tap_release_ticks <= pwdata[15:0];
                REG_TAPS_FOR_RESET:    r_taps_for_reset    <= pwdata[7:0];
                REG_TAP_WINDOW_TICKS:  r_tap_window_ticks  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_HOLD_TICKS:        prdata = {16'd0, r_hold_ticks};
            REG_LOCKOUT_TICKS:     prdata = {16'd0, r_lockout_ticks};
            REG_TAP_TICKS:         prdata = {16'd0, r_tap_ticks};
            REG_TAP_RELEASE_TICKS: prdata = {16'd0, r_tap_release_ticks};
            REG_TAPS_FOR_RESET:    prdata = {24'd0, r_taps_for_reset};
            REG_TAP_WINDOW_TICKS:  prdata = {16'd0, r_tap_window_ticks};
            default:               prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> design/blpmt_checker.sv
`default_nettype none
`include "button_long_press_and_multi_tap_defines.svh"
module blpmt_checker
    import blpmt_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tready,
    input wire logic                   i_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [8*OUT_BYTES-1:0] i_m_tdata
);

    // a start pulse always comes with a display pulse
    `BLPMT_ASSERT_IMP(a_start_display, i_clk, i_rst_n, i_m_tvalid && i_m_tdata[OB_START], i_m_tdata[OB_DISPLAY])
    // a tap reset result reads with the levels cleared
    `BLPMT_ASSERT_IMP(a_reset_levels, i_clk, i_rst_n, i_m_tvalid && i_m_tdata[OB_RESET], !i_m_tdata[OB_ACTION] && !i_m_tdata[OB_LOCKED])
    // empty output register never blocks the input
    `BLPMT_ASSERT_IMP(a_empty_ready, i_clk, i_rst_n, !i_m_tvalid, i_s_tready)
    // stalled result holds
    `BLPMT_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata))

endmodule

bind button_long_press_and_multi_tap blpmt_checker u_blpmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
`default_nettype wire

>>> dv/tb_button_long_press_and_multi_tap.sv
`default_nettype none
module tb_button_long_press_and_multi_tap
    import blpmt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ST_OTHER = 2'd3;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic start;
        logic action;
        logic display;
        logic rst;
        logic locked;
    } t_tick_result;

    logic i_clk;
    logic i_rst_n;
    logic i_s_axis_tvalid;
    logic o_s_axis_tready;
    logic [8*IN_BYTES-1:0] i_s_axis_tdata;   // [0] button_pressed, [2:1] status_code
    logic o_m_axis_tvalid;
    logic i_m_axis_tready;
    logic [8*OUT_BYTES-1:0] o_m_axis_tdata;  // [0] start, [1] action, [2] display,
                                             // [3] reset_request, [4] locked
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    button_long_press_and_multi_tap DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // detector mirror: thresholds and state
    logic [15:0] thr_hold, thr_lockout, thr_tap, thr_release, thr_window;
    logic [7:0]  thr_taps;
    logic [15:0] hold_cnt, lock_cnt, press_cnt, release_cnt, window_cnt;
    logic        long_lock, tap_lat, act_held;
    logic [7:0]  tap_total;
    bit          thresholds_defaulted;

    // per-phase thresholds, written again after a tap reset
    logic [15:0] ph_hold, ph_lockout, ph_tap, ph_release, ph_window;
    logic [7:0]  ph_taps;

    t_tick_result expected_ticks[$];

    int  cycles;
    int  n_mismatch;
    int  n_errors;
    int  n_ticks, n_results, n_long, n_taps, n_resets, n_writes;
    int  idle_mode;
    bit  no_idle;
    int  stall_left;

    task automatic detector_defaults();
        thr_hold    = RST_HOLD_TICKS;
        thr_lockout = RST_LOCKOUT_TICKS;
        thr_tap     = RST_TAP_TICKS;
        thr_release = RST_TAP_RELEASE_TICKS;
        thr_taps    = RST_TAPS_FOR_RESET;
        thr_window  = RST_TAP_WINDOW_TICKS;
        hold_cnt    = '0;
        lock_cnt    = '0;
        press_cnt   = '0;
        release_cnt = '0;
        window_cnt  = '0;
        long_lock   = 1'b0;
        tap_lat     = 1'b0;
        act_held    = 1'b0;
        tap_total   = '0;
    endtask

    task automatic predict_tick(input logic pressed, input logic [1:0] status);
        t_tick_result r;
        r = '{default: 1'b0};
        if (pressed && !long_lock) begin
            if (hold_cnt >= thr_hold) begin
                long_lock = 1'b1;
                tap_total = '0;
                if (status == ST_READY)
                    r.start = 1'b1;
                else if (status == ST_OPEN || status == ST_CLOSED)
                    act_held = 1'b1;
                else
                    act_held = 1'b0;
                r.display = 1'b1;
                n_long++;
            end else begin
                hold_cnt++;
            end
        end else begin
            hold_cnt = '0;
        end
        if (long_lock) begin
            tap_total = '0;
            lock_cnt++;
            if (lock_cnt >= thr_lockout) begin
                long_lock = 1'b0;
                lock_cnt  = '0;
                act_held  = 1'b0;
            end
        end
        if (pressed && !tap_lat) begin
            if (press_cnt >= thr_tap) begin
                tap_lat = 1'b1;
                tap_total++;
                n_taps++;
            end else begin
                press_cnt++;
            end
        end else begin
            press_cnt = '0;
        end
        if (tap_lat) begin
            release_cnt++;
            if (release_cnt >= thr_release) begin
                tap_lat     = 1'b0;
                release_cnt = '0;
            end
        end
        if (tap_total >= thr_taps) begin
            r.rst = 1'b1;
            detector_defaults();
            thresholds_defaulted = 1'b1;
            n_resets++;
        end else if (tap_total != 0) begin
            window_cnt++;
            if (window_cnt >= thr_window) begin
                tap_lat     = 1'b0;
                press_cnt   = '0;
                release_cnt = '0;
                tap_total   = '0;
                window_cnt  = '0;
            end
        end
        r.action = act_held;
        r.locked = long_lock;
        expected_ticks.push_back(r);
    endtask

    // one tick transaction; tvalid is left high for a following tick
    task automatic send_tick(input logic pressed, input logic [1:0] status);
        int gap;
        gap = 0;
        @(negedge i_clk);
        if (!no_idle && idle_mode != 0 && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 9);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, status, pressed};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_tick(pressed, status);
        n_ticks++;
    endtask

    task automatic send_run(input logic pressed, input logic [1:0] status, input int len);
        repeat (len) send_tick(pressed, status);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_HOLD_TICKS:        thr_hold    = val;
            REG_LOCKOUT_TICKS:     thr_lockout = val;
            REG_TAP_TICKS:         thr_tap     = val;
            REG_TAP_RELEASE_TICKS: thr_release = val;
            REG_TAPS_FOR_RESET:    thr_taps    = val[7:0];
            REG_TAP_WINDOW_TICKS:  thr_window  = val;
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_phase_config();
        write_reg(REG_HOLD_TICKS, ph_hold);
        write_reg(REG_LOCKOUT_TICKS, ph_lockout);
        write_reg(REG_TAP_TICKS, ph_tap);
        write_reg(REG_TAP_RELEASE_TICKS, ph_release);
        write_reg(REG_TAPS_FOR_RESET, {8'h0, ph_taps});
        write_reg(REG_TAP_WINDOW_TICKS, ph_window);
        thresholds_defaulted = 1'b0;
    endtask

    task automatic pick_phase_config();
        ph_hold    = ($urandom_range(0, 5) == 0) ? 16'd1 : 16'($urandom_range(1, 24));
        ph_lockout = ($urandom_range(0, 5) == 0) ? 16'd1 : 16'($urandom_range(1, 40));
        ph_tap     = ($urandom_range(0, 5) == 0) ? 16'd1 : 16'($urandom_range(1, 8));
        ph_release = ($urandom_range(0, 5) == 0) ? 16'd1 : 16'($urandom_range(1, 16));
        ph_taps    = ($urandom_range(0, 5) == 0) ? 8'd1 : 8'($urandom_range(1, 6));
        ph_window  = ($urandom_range(0, 5) == 0) ? 16'd1 : 16'($urandom_range(4, 80));
    endtask

    task automatic test_after_reset();
        send_tick(1'b1, ST_READY);
        send_tick(1'b0, ST_OPEN);
    endtask

    task automatic test_long_press_per_status();
        logic [1:0] st;
        wait_idle();
        write_reg(REG_HOLD_TICKS, 16'd1);
        write_reg(REG_LOCKOUT_TICKS, 16'd2);
        write_reg(REG_TAP_TICKS, 16'd40);
        write_reg(REG_TAP_RELEASE_TICKS, 16'd1);
        write_reg(REG_TAPS_FOR_RESET, 16'd255);
        write_reg(REG_TAP_WINDOW_TICKS, 16'd65535);
        for (int s = 0; s < 4; s++) begin
            st = 2'(s);
            send_run(1'b1, st, 2);
            send_tick(1'b0, st);
        end
    endtask

    task automatic test_tap_reset();
        wait_idle();
        write_reg(REG_HOLD_TICKS, 16'd65535);
        write_reg(REG_TAP_TICKS, 16'd1);
        write_reg(REG_TAPS_FOR_RESET, 16'd1);
        send_run(1'b1, ST_CLOSED, 2);
        send_tick(1'b0, ST_OTHER);
    endtask

    task automatic test_tap_window();
        wait_idle();
        write_reg(REG_TAP_TICKS, 16'd1);
        write_reg(REG_TAP_RELEASE_TICKS, 16'd1);
        write_reg(REG_TAPS_FOR_RESET, 16'd3);
        write_reg(REG_TAP_WINDOW_TICKS, 16'd1);
        send_run(1'b1, ST_OPEN, 2);
        send_run(1'b0, ST_OPEN, 2);
    endtask

    // a threshold lowered under a running count fires on the next press tick
    task automatic test_threshold_lowered();
        wait_idle();
        write_reg(REG_TAP_TICKS, 16'd65535);
        write_reg(REG_TAP_RELEASE_TICKS, 16'd65535);
        write_reg(REG_LOCKOUT_TICKS, 16'd65535);
        write_reg(REG_HOLD_TICKS, 16'd20);
        send_run(1'b1, ST_OPEN, 4);
        wait_idle();
        write_reg(REG_HOLD_TICKS, 16'd3);
        write_reg(REG_LOCKOUT_TICKS, 16'd3);
        send_run(1'b1, ST_OPEN, 2);
        send_tick(1'b0, ST_OPEN);
    endtask

    task automatic random_phase(input int n_items);
        int sent;
        int press_len, rel_len, longest;
        logic [1:0] st;
        sent = 0;
        wait_idle();
        pick_phase_config();
        apply_phase_config();
        while (sent < n_items) begin
            if (thresholds_defaulted) begin
                wait_idle();
                apply_phase_config();
            end
            if ($urandom_range(0, 9) < 8) begin
                st = 2'($urandom_range(0, 3));
                longest = (ph_hold > ph_tap) ? ph_hold : ph_tap;
                if ($urandom_range(0, 3) == 0)
                    longest += ph_lockout;
                press_len = $urandom_range(1, longest + 3);
                if ($urandom_range(0, 7) == 0) begin
                    send_run(1'b1, st, press_len / 2);
                    st = 2'($urandom_range(0, 3));
                    send_run(1'b1, st, press_len - press_len / 2);
                end else begin
                    send_run(1'b1, st, press_len);
                end
                if ($urandom_range(0, 3) == 0)
                    rel_len = $urandom_range(1, ph_window + 4);
                else
                    rel_len = $urandom_range(1, ph_release + 3);
                send_run(1'b0, st, rel_len);
                sent += press_len + rel_len;
            end else begin
                rel_len = $urandom_range(1, 12);
                repeat (rel_len)
                    send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                sent += rel_len;
            end
        end
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 7; p++)
            random_phase(240);
    endtask

    task automatic test_random_back_to_back();
        no_idle = 1'b1;
        random_phase(250);
    endtask

    // sink side: random stall bursts
    always @(negedge i_clk) begin
        logic rdy;
        rdy = 1'b1;
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (!no_idle && idle_mode != 0 && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rdy = 1'b0;
        end
        i_m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 64 == 0)
            idle_mode = $urandom_range(0, 2);
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_tick_result exp_r;
        t_tick_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.start   = o_m_axis_tdata[OB_START];
            got.action  = o_m_axis_tdata[OB_ACTION];
            got.display = o_m_axis_tdata[OB_DISPLAY];
            got.rst     = o_m_axis_tdata[OB_RESET];
            got.locked  = o_m_axis_tdata[OB_LOCKED];
            n_results++;
            if (expected_ticks.size() == 0) begin
                n_errors++;
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("Unexpected result transaction at cycle %0d: %b", cycles,
                             o_m_axis_tdata);
            end else begin
                exp_r = expected_ticks.pop_front();
                if (got.start !== exp_r.start || got.action !== exp_r.action ||
                    got.display !== exp_r.display || got.rst !== exp_r.rst ||
                    got.locked !== exp_r.locked) begin
                    n_errors++;
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        // bits: start, action, display, reset, locked
                        $display("Mismatch at cycle %0d: expected %b%b%b%b%b got %b%b%b%b%b",
                                 cycles,
                                 exp_r.start, exp_r.action, exp_r.display, exp_r.rst,
                                 exp_r.locked, got.start, got.action, got.display,
                                 got.rst, got.locked);
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        cycles          = 0;
        n_mismatch      = 0;
        n_errors        = 0;
        n_ticks         = 0;
        n_results       = 0;
        n_long          = 0;
        n_taps          = 0;
        n_resets        = 0;
        n_writes        = 0;
        idle_mode       = 1;
        no_idle         = 1'b0;
        stall_left      = 0;
        thresholds_defaulted = 1'b0;
        detector_defaults();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_long_press_per_status();
        test_tap_reset();
        test_tap_window();
        test_threshold_lowered();
        test_random_mix();
        test_random_back_to_back();

        wait_idle();
        repeat (5) @(posedge i_clk);
        if (expected_ticks.size() != 0) begin
            n_errors++;
            $display("%0d expected results never arrived", expected_ticks.size());
        end
        $display("Covered %0d ticks and %0d results: %0d long presses, %0d taps, %0d tap resets",
                 n_ticks, n_results, n_long, n_taps, n_resets);
        $display("Register writes: %0d, failures: %0d", n_writes, n_errors);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
